// ===== rtl/html_text_normalizer_top_assert.svh =====
// Assertion macros for the HTML text normalizer.
`ifndef HTML_TEXT_NORMALIZER_TOP_ASSERT_SVH
`define HTML_TEXT_NORMALIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HTN_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define HTN_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/htn_pkg.sv =====
// Shared constants and types for the HTML text normalizer.
package htn_pkg;

  localparam int unsigned MaxLen = 4096;
  localparam int unsigned AddrW  = $clog2(MaxLen);
  localparam int unsigned LenW   = AddrW + 1;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [LenW-1:0]  len_t;

  localparam logic [1:0] OpLoad  = 2'd0;
  localparam logic [1:0] OpEnd   = 2'd1;
  localparam logic [1:0] OpFetch = 2'd2;

endpackage

// ===== rtl/htn_stream_if.sv =====
// Valid/ready channel interfaces for the command input and the result output.
interface htn_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface htn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       none_left;
  logic       overflowed;

  modport source (output valid, output out_byte, output out_last, output none_left,
                  output overflowed, input ready);
  modport sink   (input valid, input out_byte, input out_last, input none_left,
                  input overflowed, output ready);
endinterface

// ===== rtl/html_text_normalizer_top.sv =====
// HTML text normalizer: text store, normalizing sequencer and result store.
// Load: one transfer per cycle. Fetch: the transfer moves to a wait state that
// loads the result into the output register once that register is free, with the
// input held off until the result is registered. Normalize walks the text store
// one scan position at a time: a six-byte window fill, a decision and up to two
// writes per position, and a read and check per byte in a closing-bracket search.
// Reset clears all control state; the stores are not cleared and need no pass.
module html_text_normalizer_top (
  input  logic clk_i,
  input  logic rst_ni,
  htn_in_if.sink    in_i,
  htn_out_if.source out_o
);
  import htn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FWAIT, S_NEXT, S_FILL, S_DECIDE, S_SREQ, S_SCHK, S_WSP, S_WCH
  } state_e;

  localparam len_t MaxLenL = len_t'(MaxLen);

  // Entity table, tried in order; names are left-aligned and space padded.
  localparam logic [0:5][7:0] EntName [0:6] = '{
    "&amp; ", "&lt;  ", "&gt;  ", "&quot;", "&#39; ", "&apos;", "&nbsp;"};
  localparam logic [2:0] EntLen  [0:6] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd5, 3'd6, 3'd6};
  localparam logic [7:0] EntChar [0:6] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h27, 8'h20};
  localparam logic [2:0] NbspIdx = 3'd6;

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
           c == 8'h0C || c == 8'h0B;
  endfunction

  function automatic logic is_tag_start(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           c == 8'h2F || c == 8'h21 || c == 8'h3F;
  endfunction

  // Returns {found, index} of the first entity that matches the window.
  function automatic logic [3:0] ent_match(input logic [0:5][7:0] w, input len_t left);
    logic [3:0] res;
    logic       ok;
    res = 4'd0;
    for (int k = 6; k >= 0; k--) begin
      ok = left >= len_t'(EntLen[k]);
      for (int m = 0; m < 6; m++) begin
        if (m < int'(EntLen[k]) && w[m] != EntName[k][m]) ok = 1'b0;
      end
      if (ok) res = {1'b1, 3'(k)};
    end
    return res;
  endfunction

  // Length of an invisible UTF-8 character at the window head, zero if none.
  function automatic logic [1:0] inv_len(input logic [0:5][7:0] w, input len_t left);
    logic [1:0] n;
    n = 2'd0;
    if (w[0] == 8'hC2) begin
      if (left >= len_t'(2) && w[1] == 8'hAD) n = 2'd2;
    end else if (left >= len_t'(3)) begin
      if (w[0] == 8'hEF && w[1] == 8'hBB && w[2] == 8'hBF) n = 2'd3;
      if (w[0] == 8'hE2 && w[1] == 8'h80 && w[2] >= 8'h8B && w[2] <= 8'h8D) n = 2'd3;
      if (w[0] == 8'hE2 && w[1] == 8'h81 && w[2] == 8'hA0) n = 2'd3;
    end
    return n;
  endfunction

  // Text and result stores, both with a registered read port.
  logic [7:0] text_mem [MaxLen];
  logic [7:0] res_mem  [MaxLen];
  logic       tw_en, rw_en;
  addr_t      tw_addr, tr_addr, rw_addr, rr_addr;
  logic [7:0] tw_data, rw_data, tr_data_q, rr_data_q;

  always_ff @(posedge clk_i) begin
    if (tw_en) text_mem[tw_addr] <= tw_data;
    tr_data_q <= text_mem[tr_addr];
  end

  always_ff @(posedge clk_i) begin
    if (rw_en) res_mem[rw_addr] <= rw_data;
    rr_data_q <= res_mem[rr_addr];
  end

  state_e          state_q, state_d;
  logic            ready_q, ready_d;     // phase: normalized text available
  len_t            tlen_q, tlen_d, rlen_q, rlen_d, fpos_q, fpos_d;
  len_t            spos_q, spos_d, cpos_q, cpos_d, jpos_q, jpos_d;
  logic            cknown_q, cknown_d, spend_q, spend_d, ovf_q, ovf_d;
  logic [2:0]      k_q, k_d;
  logic [0:5][7:0] win_q, win_d;
  logic [7:0]      emit_q, emit_d;
  logic            hit_q, hit_d, last_q, last_d;
  logic            ov_q, ov_d, ol_q, ol_d, on_q, on_d, oo_q, oo_d;
  logic [7:0]      ob_q, ob_d;

  logic       in_acc;
  len_t       left, tlen_eff;
  logic [7:0] c, lc;
  logic       is_tag, need_search;
  logic [3:0] ent;
  logic [1:0] inv;

  assign in_acc   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  assign left = tlen_q - spos_q;
  assign c    = win_q[0];
  assign is_tag = c == 8'h3C && left >= len_t'(2) && is_tag_start(win_q[1]);
  assign need_search = !cknown_q || (cpos_q < tlen_q && cpos_q < spos_q + len_t'(1));
  assign ent  = ent_match(win_q, left);
  assign inv  = inv_len(win_q, left);
  assign lc   = (emit_q >= 8'h41 && emit_q <= 8'h5A) ? emit_q + 8'h20 : emit_q;
  assign tlen_eff = ready_q ? '0 : tlen_q;

  always_comb begin
    state_d = state_q; ready_d = ready_q; tlen_d = tlen_q; rlen_d = rlen_q;
    fpos_d = fpos_q; spos_d = spos_q; cpos_d = cpos_q; jpos_d = jpos_q;
    cknown_d = cknown_q; spend_d = spend_q; ovf_d = ovf_q; k_d = k_q;
    win_d = win_q; emit_d = emit_q; hit_d = hit_q; last_d = last_q;
    ov_d = ov_q; ol_d = ol_q; on_d = on_q; oo_d = oo_q; ob_d = ob_q;
    tw_en = 1'b0; tw_addr = tlen_eff[AddrW-1:0]; tw_data = in_i.data_byte;
    rw_en = 1'b0; rw_addr = rlen_q[AddrW-1:0]; rw_data = lc;
    tr_addr = addr_t'(spos_q + len_t'(k_q));
    rr_addr = fpos_q[AddrW-1:0];

    if (ov_q && out_o.ready) ov_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.opcode == OpLoad) begin
            if (ready_q) begin
              rlen_d = '0; fpos_d = '0; ovf_d = 1'b0; ready_d = 1'b0;
            end
            if (tlen_eff < MaxLenL) begin
              tw_en  = 1'b1;
              tlen_d = tlen_eff + len_t'(1);
            end else begin
              tlen_d = tlen_eff;
              ovf_d  = 1'b1;
            end
          end else if (in_i.opcode == OpEnd) begin
            rlen_d = '0; spend_d = 1'b0; cknown_d = 1'b0; cpos_d = '0; spos_d = '0;
            state_d = S_NEXT;
          end else if (in_i.opcode == OpFetch) begin
            hit_d  = ready_q && fpos_q < rlen_q;
            last_d = fpos_q + len_t'(1) == rlen_q;
            if (ready_q && fpos_q < rlen_q) fpos_d = fpos_q + len_t'(1);
            state_d = S_FWAIT;
          end
        end
      end
      S_FWAIT: begin
        // Keep reading the fetched entry while the output register is busy.
        rr_addr = addr_t'(fpos_q - len_t'(hit_q));
        if (!ov_q || out_o.ready) begin
          ov_d = 1'b1;
          ob_d = hit_q ? rr_data_q : 8'h00;
          ol_d = hit_q && last_q;
          on_d = !hit_q;
          oo_d = ovf_q;
          state_d = S_IDLE;
        end
      end
      S_NEXT: begin
        if (spos_q < tlen_q) begin
          k_d = 3'd0;
          state_d = S_FILL;
        end else begin
          fpos_d = '0; ready_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FILL: begin
        if (k_q != 3'd0) win_d[k_q - 3'd1] = tr_data_q;
        k_d = k_q + 3'd1;
        if (k_q == 3'd6) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_NEXT;
        if (is_tag && need_search) begin
          jpos_d  = spos_q + len_t'(1);
          state_d = S_SREQ;
        end else if (is_tag && cpos_q < tlen_q) begin
          spend_d = rlen_q != '0;
          spos_d  = cpos_q + len_t'(1);
        end else if (c == 8'h26) begin
          if (ent[3]) begin
            spos_d = spos_q + len_t'(EntLen[ent[2:0]]);
            if (ent[2:0] == NbspIdx) begin
              spend_d = rlen_q != '0;
            end else begin
              emit_d  = EntChar[ent[2:0]];
              state_d = S_WSP;
            end
          end else begin
            emit_d  = c;
            spos_d  = spos_q + len_t'(1);
            state_d = S_WSP;
          end
        end else if (is_space(c)) begin
          spend_d = rlen_q != '0;
          spos_d  = spos_q + len_t'(1);
        end else if (c >= 8'h80 && inv != 2'd0) begin
          spos_d = spos_q + len_t'(inv);
        end else begin
          emit_d  = c;
          spos_d  = spos_q + len_t'(1);
          state_d = S_WSP;
        end
      end
      S_SREQ: begin
        tr_addr = jpos_q[AddrW-1:0];
        if (jpos_q < tlen_q) begin
          state_d = S_SCHK;
        end else begin
          cpos_d = tlen_q; cknown_d = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_SCHK: begin
        if (tr_data_q == 8'h3E) begin
          cpos_d = jpos_q; cknown_d = 1'b1;
          state_d = S_DECIDE;
        end else begin
          jpos_d  = jpos_q + len_t'(1);
          state_d = S_SREQ;
        end
      end
      S_WSP: begin
        if (spend_q && rlen_q < MaxLenL) begin
          rw_en   = 1'b1;
          rw_data = 8'h20;
          rlen_d  = rlen_q + len_t'(1);
        end
        spend_d = 1'b0;
        state_d = S_WCH;
      end
      S_WCH: begin
        if (rlen_q < MaxLenL) begin
          rw_en  = 1'b1;
          rlen_d = rlen_q + len_t'(1);
        end
        state_d = S_NEXT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ready_q <= 1'b0; tlen_q <= '0; rlen_q <= '0; fpos_q <= '0;
      spos_q <= '0; cpos_q <= '0; jpos_q <= '0; cknown_q <= 1'b0; spend_q <= 1'b0;
      ovf_q <= 1'b0; k_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d; ready_q <= ready_d; tlen_q <= tlen_d; rlen_q <= rlen_d;
      fpos_q <= fpos_d; spos_q <= spos_d; cpos_q <= cpos_d; jpos_q <= jpos_d;
      cknown_q <= cknown_d; spend_q <= spend_d; ovf_q <= ovf_d; k_q <= k_d;
      ov_q <= ov_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    win_q <= win_d; emit_q <= emit_d; hit_q <= hit_d; last_q <= last_d;
    ob_q <= ob_d; ol_q <= ol_d; on_q <= on_d; oo_q <= oo_d;
  end

  assign out_o.valid      = ov_q;
  assign out_o.out_byte   = ob_q;
  assign out_o.out_last   = ol_q;
  assign out_o.none_left  = on_q;
  assign out_o.overflowed = oo_q;

`include "html_text_normalizer_top_assert.svh"

  `HTN_ASSERT_NOW(a_rlen_bound, 1'b1, rlen_q <= MaxLenL && tlen_q <= MaxLenL, "length past store")
  `HTN_ASSERT_NOW(a_none_zero, ov_q && on_q, ob_q == 8'h00 && !ol_q, "empty result carries data")
  `HTN_ASSERT_NEXT(a_fetch_wait, in_acc && in_i.opcode == OpFetch, state_q == S_FWAIT, "fetch lost")

endmodule
